>>> design/shpf_pkg.sv
// Shared types and constants for the sync header packet framer.
package shpf_pkg;

	localparam logic [7:0] HDR_FIRST = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam int IDX_W = 4;
	localparam int CNT_W = 32;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TAKE = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT1 = 2'd0,
		PH_HUNT2 = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_DRAIN = 1'b1
	} seq_t;

endpackage

>>> design/shpf_if.sv
// Handshake channel interfaces for the framer input items and result items.
interface shpf_req_if;
	logic valid;
	logic ready;
	logic mode;
	logic [7:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

interface shpf_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] packet_byte;
	logic [3:0] byte_index;
	logic last;
	logic packet_valid;
	logic ready_res;
	logic byte_dropped;
	logic error_event;
	logic packet_event;
	logic [31:0] bytes_count;
	logic [31:0] packets_count;
	logic [31:0] errors_count;

	modport source (output valid, packet_byte, byte_index, last, packet_valid, ready_res,
		byte_dropped, error_event, packet_event, bytes_count, packets_count,
		errors_count, input ready);
	modport sink (input valid, packet_byte, byte_index, last, packet_valid, ready_res,
		byte_dropped, error_event, packet_event, bytes_count, packets_count,
		errors_count, output ready);
endinterface

>>> design/sync_header_packet_framer.sv
// Top level of the sync header packet framer: header hunt, packet store and readout.
// A received byte item yields a single result, loaded into the result register; a take
// with no packet held behaves the same way. A take with a held packet runs PACKET_LEN
// results, one per cycle while the downstream side takes them, each read from the
// packet memory through its registered read data; no new item is accepted until the
// last one is loaded. After arst_n the framer hunts for the first header byte, no
// packet is held and all counters read zero; the packet memory itself is not cleared.
module sync_header_packet_framer import shpf_pkg::*; #(
	parameter int PACKET_LEN = 9
) (
	input logic clk,
	input logic arst_n,
	shpf_req_if.sink req,
	shpf_rsp_if.source rsp
);

	localparam int AW = (PACKET_LEN > 1) ? $clog2(PACKET_LEN) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_LEN - 1);

	// Framer control state.
	phase_t phase_q, phase_d;
	seq_t seq_q, seq_d;
	logic [IDX_W-1:0] fill_q, fill_d;
	logic [7:0] check_q, check_d;
	logic held_q, held_d;
	logic [CNT_W-1:0] rcv_q, rcv_d;
	logic [CNT_W-1:0] good_q, good_d;
	logic [CNT_W-1:0] err_q, err_d;
	logic [IDX_W-1:0] drain_idx_q, drain_idx_d;

	// The packet store is a single-port-write, single-read synchronous memory.
	// Writes happen only on idle byte items and reads only on a take or while
	// draining, so the two never touch the same entry in the same cycle.
	logic [7:0] mem_q [PACKET_LEN];
	logic [7:0] rd_data_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic rd_en;
	logic [AW-1:0] rd_addr;

	// Result register that separates the framer from the downstream side.
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic [IDX_W-1:0] out_idx_q;
	logic out_last_q, out_pvalid_q, out_ready_res_q;
	logic out_dropped_q, out_err_q, out_good_q;
	logic [CNT_W-1:0] out_rcv_q, out_good_cnt_q, out_err_cnt_q;

	logic out_free;
	logic accept;
	logic load;
	logic [7:0] ld_byte;
	logic [IDX_W-1:0] ld_idx;
	logic ld_last, ld_pvalid, ld_dropped, ld_err, ld_good;
	logic [IDX_W-1:0] pos;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (seq_q == SEQ_IDLE) && out_free;
	assign accept = req.valid && req.ready;

	// Next state, memory access and result selection.
	always_comb begin
		phase_d = phase_q;
		seq_d = seq_q;
		fill_d = fill_q;
		check_d = check_q;
		held_d = held_q;
		rcv_d = rcv_q;
		good_d = good_q;
		err_d = err_q;
		drain_idx_d = drain_idx_q;
		wr_en = 1'b0;
		wr_addr = '0;
		rd_en = 1'b0;
		rd_addr = '0;
		load = 1'b0;
		ld_byte = '0;
		ld_idx = '0;
		ld_last = 1'b1;
		ld_pvalid = 1'b0;
		ld_dropped = 1'b0;
		ld_err = 1'b0;
		ld_good = 1'b0;
		// A fill count past the packet end is clamped onto the final byte.
		pos = ({1'b0, fill_q} >= (IDX_W + 1)'(PACKET_LEN)) ? LAST_IDX : fill_q;

		case (seq_q)
			SEQ_IDLE: begin
				if (accept && req.mode == MODE_TAKE) begin
					if (held_q) begin
						// Free the buffer now and start reading entry zero.
						held_d = 1'b0;
						seq_d = SEQ_DRAIN;
						drain_idx_d = '0;
						rd_en = 1'b1;
						rd_addr = '0;
					end else begin
						load = 1'b1;
					end
				end else if (accept) begin
					load = 1'b1;
					rcv_d = rcv_q + 1'b1;
					if (held_q) begin
						ld_dropped = 1'b1;
					end else begin
						case (phase_q)
							PH_HUNT2: begin
								if (req.data_byte == HDR_SECOND) begin
									wr_en = 1'b1;
									wr_addr = AW'(1);
									check_d = check_q ^ req.data_byte;
									fill_d = IDX_W'(2);
									phase_d = PH_COLLECT;
								end else begin
									// A wrong second byte is an error and is not
									// retried as a first header byte.
									err_d = err_q + 1'b1;
									ld_err = 1'b1;
									phase_d = PH_HUNT1;
									fill_d = '0;
									check_d = '0;
								end
							end
							PH_COLLECT: begin
								wr_en = 1'b1;
								wr_addr = pos[AW-1:0];
								if (pos == LAST_IDX) begin
									if (check_q == req.data_byte) begin
										held_d = 1'b1;
										good_d = good_q + 1'b1;
										ld_good = 1'b1;
									end else begin
										err_d = err_q + 1'b1;
										ld_err = 1'b1;
									end
									phase_d = PH_HUNT1;
									fill_d = '0;
									check_d = '0;
								end else begin
									check_d = check_q ^ req.data_byte;
									fill_d = pos + 1'b1;
								end
							end
							default: begin
								// Hunting the first header byte; an unused phase
								// code lands here as well.
								if (req.data_byte == HDR_FIRST) begin
									wr_en = 1'b1;
									wr_addr = '0;
									check_d = req.data_byte;
									fill_d = IDX_W'(1);
									phase_d = PH_HUNT2;
								end else begin
									phase_d = PH_HUNT1;
									fill_d = '0;
									check_d = '0;
								end
							end
						endcase
					end
				end
			end
			SEQ_DRAIN: begin
				// The memory word for drain_idx_q sits in rd_data_q; it is only
				// replaced once it has been loaded into the result register.
				if (out_free) begin
					load = 1'b1;
					ld_byte = rd_data_q;
					ld_idx = drain_idx_q;
					ld_pvalid = 1'b1;
					ld_last = (drain_idx_q == LAST_IDX);
					if (drain_idx_q == LAST_IDX) begin
						seq_d = SEQ_IDLE;
					end else begin
						drain_idx_d = drain_idx_q + 1'b1;
						rd_en = 1'b1;
						rd_addr = drain_idx_d[AW-1:0];
					end
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			seq_q <= SEQ_IDLE;
			fill_q <= '0;
			check_q <= '0;
			held_q <= 1'b0;
			rcv_q <= '0;
			good_q <= '0;
			err_q <= '0;
			drain_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			seq_q <= seq_d;
			fill_q <= fill_d;
			check_q <= check_d;
			held_q <= held_d;
			rcv_q <= rcv_d;
			good_q <= good_d;
			err_q <= err_d;
			drain_idx_q <= drain_idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the counters and held flag shown are the values after the step.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= ld_byte;
			out_idx_q <= ld_idx;
			out_last_q <= ld_last;
			out_pvalid_q <= ld_pvalid;
			out_ready_res_q <= held_d;
			out_dropped_q <= ld_dropped;
			out_err_q <= ld_err;
			out_good_q <= ld_good;
			out_rcv_q <= rcv_d;
			out_good_cnt_q <= good_d;
			out_err_cnt_q <= err_d;
		end
	end

	// Packet memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= req.data_byte;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.packet_byte = out_byte_q;
	assign rsp.byte_index = out_idx_q;
	assign rsp.last = out_last_q;
	assign rsp.packet_valid = out_pvalid_q;
	assign rsp.ready_res = out_ready_res_q;
	assign rsp.byte_dropped = out_dropped_q;
	assign rsp.error_event = out_err_q;
	assign rsp.packet_event = out_good_q;
	assign rsp.bytes_count = out_rcv_q;
	assign rsp.packets_count = out_good_cnt_q;
	assign rsp.errors_count = out_err_cnt_q;

`ifndef SYNTHESIS
	// No item is taken while a held packet is being read out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_DRAIN) |-> !req.ready)
		else $error("input accepted during packet readout");

	// A held packet always leaves the framer back in the hunt with no partial fill.
	assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> (phase_q == PH_HUNT1 && fill_q == '0))
		else $error("framer not hunting while a packet is held");

	// Readout results never report a held packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.packet_valid) |-> !rsp.ready_res)
		else $error("readout result reports packet still held");

	// A take of a held packet starts a readout in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_TAKE && held_q) |=> (seq_q == SEQ_DRAIN))
		else $error("take of held packet did not start readout");
`endif

endmodule

>>> tb/framer_check_pkg.sv
// Expected-result tracking and result checking for the sync header packet framer.
package framer_check_pkg;
	import shpf_pkg::*;

	localparam int PKT_LEN = 9;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic [3:0] byte_index;
		logic last;
		logic packet_valid;
		logic ready_res;
		logic byte_dropped;
		logic error_event;
		logic packet_event;
		logic [31:0] bytes_count;
		logic [31:0] packets_count;
		logic [31:0] errors_count;
	} frame_result_t;

	class frame_tracker;
		frame_result_t due_results[$];
		int unsigned fault_count;
		phase_t phase;
		logic [3:0] fill;
		logic [7:0] store[PKT_LEN];
		logic held;
		logic [7:0] chk;
		logic [31:0] rx_total;
		logic [31:0] good_total;
		logic [31:0] err_total;

		function new();
			phase = PH_HUNT1;
			fill = '0;
			held = 1'b0;
			chk = '0;
			rx_total = '0;
			good_total = '0;
			err_total = '0;
			fault_count = 0;
			foreach (store[i])
				store[i] = '0;
		endfunction

		function void restart_hunt();
			phase = PH_HUNT1;
			fill = '0;
			chk = '0;
		endfunction

		function frame_result_t blank_result();
			frame_result_t r;
			r = '0;
			r.last = 1'b1;
			r.ready_res = held;
			r.bytes_count = rx_total;
			r.packets_count = good_total;
			r.errors_count = err_total;
			return r;
		endfunction

		// Works out the results of one accepted item and advances the framer state.
		function void take_input(logic m, logic [7:0] d);
			frame_result_t r;
			int pos;
			if (m == MODE_TAKE) begin
				if (!held) begin
					due_results.push_back(blank_result());
					return;
				end
				held = 1'b0;
				for (int i = 0; i < PKT_LEN; i++) begin
					r = blank_result();
					r.packet_byte = store[i];
					r.byte_index = 4'(i);
					r.last = (i == PKT_LEN - 1);
					r.packet_valid = 1'b1;
					due_results.push_back(r);
				end
				return;
			end
			rx_total++;
			r = blank_result();
			if (held) begin
				r.byte_dropped = 1'b1;
			end else begin
				case (phase)
					PH_HUNT2: begin
						if (d == HDR_SECOND) begin
							store[1] = d;
							chk ^= d;
							fill = 4'd2;
							phase = PH_COLLECT;
						end else begin
							err_total++;
							r.error_event = 1'b1;
							restart_hunt();
						end
					end
					PH_COLLECT: begin
						pos = fill;
						if (pos >= PKT_LEN)
							pos = PKT_LEN - 1;
						store[pos] = d;
						if (pos + 1 >= PKT_LEN) begin
							if (chk == d) begin
								held = 1'b1;
								good_total++;
								r.packet_event = 1'b1;
							end else begin
								err_total++;
								r.error_event = 1'b1;
							end
							restart_hunt();
						end else begin
							chk ^= d;
							fill = 4'(pos + 1);
						end
					end
					default: begin
						if (d == HDR_FIRST) begin
							store[0] = d;
							chk = d;
							fill = 4'd1;
							phase = PH_HUNT2;
						end else begin
							restart_hunt();
						end
					end
				endcase
			end
			r.ready_res = held;
			r.bytes_count = rx_total;
			r.packets_count = good_total;
			r.errors_count = err_total;
			due_results.push_back(r);
		endfunction

		function string show(frame_result_t r);
			return $sformatf("byte=%h idx=%0d last=%b pv=%b rdy=%b drop=%b err=%b pkt=%b cnt=%0d/%0d/%0d",
				r.packet_byte, r.byte_index, r.last, r.packet_valid, r.ready_res,
				r.byte_dropped, r.error_event, r.packet_event, r.bytes_count,
				r.packets_count, r.errors_count);
		endfunction

		function void report_fault(string what, frame_result_t want, frame_result_t got);
			fault_count++;
			if (fault_count <= 10)
				$display("mismatch (%s)\n  expected %s\n  actual   %s", what, show(want),
					show(got));
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			string diff;
			if (due_results.size() == 0) begin
				report_fault("no result outstanding", '0, got);
				return;
			end
			want = due_results.pop_front();
			diff = "";
			if (got.packet_byte !== want.packet_byte) diff = {diff, " packet_byte"};
			if (got.byte_index !== want.byte_index) diff = {diff, " byte_index"};
			if (got.last !== want.last) diff = {diff, " last"};
			if (got.packet_valid !== want.packet_valid) diff = {diff, " packet_valid"};
			if (got.ready_res !== want.ready_res) diff = {diff, " ready_res"};
			if (got.byte_dropped !== want.byte_dropped) diff = {diff, " byte_dropped"};
			if (got.error_event !== want.error_event) diff = {diff, " error_event"};
			if (got.packet_event !== want.packet_event) diff = {diff, " packet_event"};
			if (got.bytes_count !== want.bytes_count) diff = {diff, " bytes_count"};
			if (got.packets_count !== want.packets_count) diff = {diff, " packets_count"};
			if (got.errors_count !== want.errors_count) diff = {diff, " errors_count"};
			if (diff != "")
				report_fault(diff, want, got);
		endfunction

		function void finish_check();
			if (due_results.size() != 0) begin
				fault_count++;
				$display("%0d expected results never arrived", due_results.size());
			end
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
// Self-checking testbench for the sync header packet framer.
module tb_top;
	import shpf_pkg::*;
	import framer_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;

	shpf_req_if req();
	shpf_rsp_if rsp();

	sync_header_packet_framer #(
		.PACKET_LEN(PKT_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	frame_tracker board = new();

	// Percent chance per cycle that the sender holds off or the receiver stalls.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;

	// Result side: every result taken at a clock edge is compared against the oldest
	// expectation. The sampled values are the ones from before the edge, so the check
	// does not depend on when the block's own registers update.
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.packet_byte = rsp.packet_byte;
			got.byte_index = rsp.byte_index;
			got.last = rsp.last;
			got.packet_valid = rsp.packet_valid;
			got.ready_res = rsp.ready_res;
			got.byte_dropped = rsp.byte_dropped;
			got.error_event = rsp.error_event;
			got.packet_event = rsp.packet_event;
			got.bytes_count = rsp.bytes_count;
			got.packets_count = rsp.packets_count;
			got.errors_count = rsp.errors_count;
			board.check_result(got);
		end
		rsp.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Offers one item, with a random hold-off in front of it, and waits until the block
	// takes it. The valid line stays high straight into the next item when no gap is
	// drawn, so back-to-back transfers get exercised as well.
	task automatic send_item(input logic m, input logic [7:0] d);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.data_byte <= d;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		board.take_input(m, d);
		items_sent++;
	endtask

	// Sends a complete frame: header, six body bytes and a checksum. A nonzero spoil
	// value is folded into the checksum byte so that the frame fails its check.
	task automatic send_frame(input logic [47:0] body, input logic [7:0] spoil);
		logic [7:0] sum;
		sum = HDR_FIRST ^ HDR_SECOND;
		send_item(MODE_BYTE, HDR_FIRST);
		send_item(MODE_BYTE, HDR_SECOND);
		for (int k = 5; k >= 0; k--) begin
			sum ^= body[8*k +: 8];
			send_item(MODE_BYTE, body[8*k +: 8]);
		end
		send_item(MODE_BYTE, sum ^ spoil);
	endtask

	// The sender goes quiet until every outstanding result has come back.
	task automatic drain_results();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.due_results.size() != 0);
	endtask

	// Random traffic. Most of it is well-formed frames with random content, since only
	// those reach the held-packet path; the rest is bad checksums, broken headers, stray
	// bytes and takes, some of them landing on an empty buffer.
	task automatic run_random(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		logic [7:0] spoil;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_frame({$urandom(), 16'($urandom())}, 8'h00);
				if ($urandom_range(99) < 65)
					send_item(MODE_TAKE, 8'($urandom()));
			end else if (pick < 60) begin
				spoil = 8'($urandom_range(255, 1));
				send_frame({$urandom(), 16'($urandom())}, spoil);
			end else if (pick < 70) begin
				// First header byte followed by anything; mostly not the second one.
				send_item(MODE_BYTE, HDR_FIRST);
				send_item(MODE_BYTE, ($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom()));
			end else if (pick < 85) begin
				send_item(MODE_BYTE, 8'($urandom()));
			end else begin
				send_item(MODE_TAKE, 8'($urandom()));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_BYTE;
		req.data_byte <= 8'h00;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with both sides running flat out.
		// A take with nothing held yields one empty result.
		send_item(MODE_TAKE, 8'hFF);
		// Stray bytes at both ends of the range are ignored by the hunt.
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'hFF);
		// A wrong second header byte is an error, and that byte does not restart the
		// header; the following 0x55 therefore falls on the hunt and is ignored.
		send_item(MODE_BYTE, HDR_FIRST);
		send_item(MODE_BYTE, HDR_FIRST);
		send_item(MODE_BYTE, HDR_SECOND);
		// A good frame whose body carries the header pattern, which must not rehunt.
		send_frame(48'hAA55_FF00_1280, 8'h00);
		// Bytes arriving while the packet is held are dropped but counted.
		send_item(MODE_BYTE, HDR_FIRST);
		send_item(MODE_BYTE, 8'h7F);
		// Read the packet out, then a second take finds the buffer empty.
		send_item(MODE_TAKE, 8'h00);
		send_item(MODE_TAKE, 8'h80);
		// A frame with a bad checksum counts an error and leaves nothing held.
		send_frame(48'hFFFF_FFFF_FFFF, 8'h01);
		drain_results();

		// Random part, in phases with different amounts of idling on each side.
		idle_pct = 0;
		stall_pct = 0;
		run_random(80);
		drain_results();
		idle_pct = 49;
		stall_pct = 0;
		run_random(80);
		drain_results();
		idle_pct = 0;
		stall_pct = 49;
		run_random(80);
		drain_results();
		idle_pct = 35;
		stall_pct = 35;
		run_random(80);
		drain_results();

		// Give the block time to show any stray result before the verdict.
		repeat (20)
			@(posedge clk);
		board.finish_check();
		if (board.fault_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

>>> filelist.f
design/shpf_pkg.sv
design/shpf_if.sv
design/sync_header_packet_framer.sv
tb/framer_check_pkg.sv
tb/tb_top.sv
